/* rtl/dtti_pkg.sv */
// ----------------------------------------------------------------------------
// dtti_pkg
// Shared types, constants and character class helpers for the decimal
// text to int32 converter.
// ----------------------------------------------------------------------------
package dtti_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  // magnitude times ten plus a digit, with headroom for the limit compare
  localparam int PROD_W  = VALUE_W + 3;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [PROD_W-1:0] LIMIT_POS = PROD_W'(32'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] LIMIT_NEG = PROD_W'(32'h8000_0000);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               used_fallback;
  } result_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

/* rtl/decimal_text_to_int32_core.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_int32_core
// Streaming ASCII decimal text to signed 32-bit integer, one byte per item.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tuser
//  in_     | in  | [7:0] char_code       | -
//  out_    | out | [31:0] value          | [0] used_fallback
//  cfg_    | in  | [31:0] fallback_value | - (write enable only)
//
//  one item per cycle unless a terminator stalls; phase/magnitude registered
//  a terminator byte passes the input register, then the result register
//  a held result stalls only a following terminator; other bytes keep flowing
//  reset: synchronous rst_n low, clears parse state and fallback_value to 0
// ----------------------------------------------------------------------------
module decimal_text_to_int32_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [dtti_pkg::CHAR_W-1:0]  in_tdata,   // [7:0] char_code
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dtti_pkg::VALUE_W-1:0] out_tdata,  // [31:0] value
  output logic                         out_tuser,  // [0] used_fallback
  input  logic                         cfg_wr_en,
  input  logic [dtti_pkg::VALUE_W-1:0] cfg_wr_data
);

  logic                         hold_valid;
  logic [dtti_pkg::CHAR_W-1:0]  hold_char;
  logic                         take;
  logic                         is_term;
  logic                         out_full;
  dtti_pkg::result_t            result;
  logic [dtti_pkg::VALUE_W-1:0] fallback_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= '0;
    end else if (cfg_wr_en) begin
      fallback_r <= cfg_wr_data;
    end
  end

  // only a terminator needs room in the result register
  assign take = hold_valid && (!is_term || !out_full || out_tready);

  dtti_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_char  (hold_char)
  );

  dtti_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (take),
    .char_code      (hold_char),
    .fallback_value (fallback_r),
    .is_term        (is_term),
    .result         (result)
  );

  dtti_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && is_term),
    .result     (result),
    .full       (out_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/dtti_in_stage.sv */
// ----------------------------------------------------------------------------
// dtti_in_stage
// Input register: holds one text byte until the parser takes it.
// ----------------------------------------------------------------------------
module dtti_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [dtti_pkg::CHAR_W-1:0] in_tdata,
  input  logic                        take,
  output logic                        hold_valid,
  output logic [dtti_pkg::CHAR_W-1:0] hold_char
);

  logic                        valid_r;
  logic [dtti_pkg::CHAR_W-1:0] char_r;

  assign in_tready  = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_char  = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
    end
  end

endmodule

/* rtl/dtti_parse.sv */
// ----------------------------------------------------------------------------
// dtti_parse
// Parser state and per-byte update: phase, sign and magnitude, with the
// overflow check and the result formed at the terminator.
// ----------------------------------------------------------------------------
module dtti_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [dtti_pkg::CHAR_W-1:0]  char_code,
  input  logic [dtti_pkg::VALUE_W-1:0] fallback_value,
  output logic                         is_term,
  output dtti_pkg::result_t            result
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_FAIL   = 3'd4
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic                         neg_r, neg_nxt;
  logic [dtti_pkg::VALUE_W-1:0] mag_r, mag_nxt;

  logic [dtti_pkg::PROD_W-1:0]  mag_ext;
  logic [dtti_pkg::PROD_W-1:0]  acc_sum;
  logic [dtti_pkg::PROD_W-1:0]  limit;
  logic                         ovf;
  logic                         ws;
  logic                         dig;
  logic                         ok;

  assign is_term = (char_code == dtti_pkg::CH_NUL);
  assign ws      = dtti_pkg::is_ws(char_code);
  assign dig     = dtti_pkg::is_digit(char_code);

  // mag * 10 + digit as two shifts and two adds
  assign mag_ext = dtti_pkg::PROD_W'(mag_r);
  assign acc_sum = (mag_ext << 3) + (mag_ext << 1)
                 + dtti_pkg::PROD_W'(char_code - dtti_pkg::CH_ZERO);
  assign limit   = neg_r ? dtti_pkg::LIMIT_NEG : dtti_pkg::LIMIT_POS;
  assign ovf     = acc_sum > limit;

  assign ok = (phase_r == PH_DIGITS) || (phase_r == PH_TRAIL);
  assign result.value         = ok ? (neg_r ? (~mag_r + 1'b1) : mag_r) : fallback_value;
  assign result.used_fallback = !ok;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    if (is_term) begin
      phase_nxt = PH_LEAD;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (ws) begin
            phase_nxt = PH_LEAD;
          end else if (char_code == dtti_pkg::CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGN;
          end else if (dig && !ovf) begin
            mag_nxt   = acc_sum[dtti_pkg::VALUE_W-1:0];
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_SIGN: begin
          if (dig && !ovf) begin
            mag_nxt   = acc_sum[dtti_pkg::VALUE_W-1:0];
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (dig) begin
            if (ovf) begin
              phase_nxt = PH_FAIL;
            end else begin
              mag_nxt = acc_sum[dtti_pkg::VALUE_W-1:0];
            end
          end else if (ws) begin
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_TRAIL: begin
          if (!ws) begin
            phase_nxt = PH_FAIL;
          end
        end
        default: begin
          phase_nxt = PH_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      neg_r   <= 1'b0;
      mag_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
    end
  end

endmodule

/* rtl/dtti_out_stage.sv */
// ----------------------------------------------------------------------------
// dtti_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dtti_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  dtti_pkg::result_t            result,
  output logic                         full,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dtti_pkg::VALUE_W-1:0] out_tdata,
  output logic                         out_tuser
);

  logic              valid_r;
  dtti_pkg::result_t res_r;

  assign full       = valid_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.value;
  assign out_tuser  = res_r.used_fallback;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      res_r <= result;
    end
  end

endmodule

/* rtl/dtti_checker.sv */
// ----------------------------------------------------------------------------
// dtti_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module dtti_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [dtti_pkg::CHAR_W-1:0]  in_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [dtti_pkg::VALUE_W-1:0] out_tdata,
  input logic                         out_tuser,
  input logic                         cfg_wr_en,
  input logic [dtti_pkg::VALUE_W-1:0] cfg_wr_data
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result dropped or changed");

  // terminator accepted with an empty result register must show up as a result
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata == dtti_pkg::CH_NUL) && !out_tvalid
    |=> ##1 out_tvalid)
    else $error("terminator gave no result");

  // a fallback result carries the configured value when config is steady
  a_fallback_value: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && out_tuser && !$past(cfg_wr_en) && !$past(cfg_wr_en, 2)
    && !$past(cfg_wr_en, 3) && $past(rst_n, 3)
    |-> out_tdata == $past(cfg_wr_data, 4) || !$past(cfg_wr_en, 4))
    else $error("fallback result does not match configured value");

endmodule

bind decimal_text_to_int32_core dtti_checker u_dtti_checker (.*);

/* tb/tb_decimal_text_to_int32_core.sv */
// ----------------------------------------------------------------------------
// tb_decimal_text_to_int32_core
// Self-checking bench for the decimal text to int32 converter. Text bytes are
// streamed in with random gaps, results are drained with random stalls and one
// or two long hold-offs, and every result is checked against a bit-exact
// predictor of the parser. The fallback register is swept through several
// settings, the extremes among them, between idle phases.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_int32_core;
  import dtti_pkg::*;

  localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
  localparam int BYTES_PER_PHASE = 200;
  localparam int NUM_PHASES      = 7;
  localparam int TAIL_CYCLES     = 8;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int RUN_LIMIT       = 400000;

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_SIGN,
    SCAN_DIGITS,
    SCAN_TRAIL,
    SCAN_FAIL
  } scan_phase_e;

  class parsed_int_scoreboard;
    scan_phase_e        phase;
    bit                 negative;
    logic [VALUE_W-1:0] magnitude;
    logic [VALUE_W-1:0] fallback;
    result_t            expected_ints[$];
    int                 errors;
    int                 checked;
    int                 fallbacks;

    function new();
      fallback  = '0;
      errors    = 0;
      checked   = 0;
      fallbacks = 0;
      clear();
    endfunction

    function void clear();
      phase     = SCAN_LEAD;
      negative  = 1'b0;
      magnitude = '0;
    endfunction

    function bit is_blank(logic [CHAR_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
             c == CH_VT || c == CH_FF;
    endfunction

    function bit is_decimal(logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // grow the magnitude by one digit, failing once it passes the signed limit
    function void take_digit(logic [CHAR_W-1:0] c);
      logic [35:0]        grown;
      logic [VALUE_W-1:0] limit;
      limit = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
      grown = 36'(magnitude) * 36'd10 + 36'(c - CH_ZERO);
      if (grown > 36'(limit)) begin
        phase = SCAN_FAIL;
      end else begin
        magnitude = grown[VALUE_W-1:0];
        phase     = SCAN_DIGITS;
      end
    endfunction

    function void take_char(logic [CHAR_W-1:0] c);
      result_t r;
      if (c == CH_NUL) begin
        r.used_fallback = !(phase == SCAN_DIGITS || phase == SCAN_TRAIL);
        if (r.used_fallback)
          r.value = fallback;
        else
          r.value = negative ? (32'd0 - magnitude) : magnitude;
        expected_ints.push_back(r);
        clear();
        return;
      end
      case (phase)
        SCAN_LEAD: begin
          if (is_blank(c)) begin
          end else if (c == CH_MINUS) begin
            negative = 1'b1;
            phase    = SCAN_SIGN;
          end else if (is_decimal(c)) begin
            take_digit(c);
          end else begin
            phase = SCAN_FAIL;
          end
        end
        SCAN_SIGN: begin
          if (is_decimal(c)) take_digit(c);
          else phase = SCAN_FAIL;
        end
        SCAN_DIGITS: begin
          if (is_decimal(c)) take_digit(c);
          else if (is_blank(c)) phase = SCAN_TRAIL;
          else phase = SCAN_FAIL;
        end
        SCAN_TRAIL: begin
          if (!is_blank(c)) phase = SCAN_FAIL;
        end
        default: begin
          phase = SCAN_FAIL;
        end
      endcase
    endfunction

    function int pending();
      return expected_ints.size();
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_int(logic [VALUE_W-1:0] value, logic used_fallback);
      result_t exp_r;
      if (expected_ints.size() == 0) begin
        report($sformatf("unexpected result value=%0d used_fallback=%0b",
                         $signed(value), used_fallback));
        return;
      end
      exp_r = expected_ints.pop_front();
      checked++;
      if (exp_r.used_fallback) fallbacks++;
      if (value !== exp_r.value)
        report($sformatf("result %0d: value %0d, expected %0d", checked,
                         $signed(value), $signed(exp_r.value)));
      if (used_fallback !== exp_r.used_fallback)
        report($sformatf("result %0d: used_fallback %0b, expected %0b", checked,
                         used_fallback, exp_r.used_fallback));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [CHAR_W-1:0]  in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [VALUE_W-1:0] out_tdata;
  logic               out_tuser;
  logic               cfg_wr_en;
  logic [VALUE_W-1:0] cfg_wr_data;

  parsed_int_scoreboard sb;
  int                   bytes_sent = 0;
  int                   texts_sent = 0;
  bit                   tx_burst   = 1'b0;

  decimal_text_to_int32_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.take_char(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_int(out_tdata, out_tuser);
  end

  initial begin
    #(RUN_LIMIT * 8);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("decimal_text_to_int32_core regression: fail");
    $finish;
  end

  // result drain: random stalls, idle-free stretches and a couple of long holds
  initial begin
    int stall;
    bit rx_burst;
    int holds;
    out_tready = 1'b0;
    rx_burst   = 1'b0;
    holds      = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (holds < 2 && sb.checked >= 20 + holds * 60) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        holds++;
      end
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(ref logic [CHAR_W-1:0] t[$]);
    tx_burst = ($urandom_range(0, 3) == 0);
    foreach (t[i]) send_char(t[i]);
    texts_sent++;
  endtask

  task automatic add_str(ref logic [CHAR_W-1:0] t[$], input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // bias toward the int32 limits and past 2^32 to catch accumulator wrap
  function automatic longint unsigned pick_magnitude();
    case ($urandom_range(0, 7))
      0: return 64'($urandom_range(0, 9));
      1: return 64'($urandom_range(0, 99999));
      2: return 64'($urandom);
      3: return 64'($urandom & 32'h7FFF_FFFF);
      4: return 64'd2147483640 + 64'($urandom_range(0, 15));
      5: return (64'($urandom) << 8) | 64'($urandom_range(0, 255));
      6: return 64'd4294967290 + 64'($urandom_range(0, 9));
      default: return 64'd0;
    endcase
  endfunction

  task automatic add_number(ref logic [CHAR_W-1:0] t[$]);
    repeat ($urandom_range(0, 3)) t.push_back(pick_blank());
    if ($urandom_range(0, 1)) t.push_back(CH_MINUS);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) t.push_back(CH_ZERO);
    add_str(t, $sformatf("%0d", pick_magnitude()));
    repeat ($urandom_range(0, 2)) t.push_back(pick_blank());
  endtask

  task automatic make_random_text(ref logic [CHAR_W-1:0] t[$]);
    int kind;
    t.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      add_number(t);
    end else if (kind <= 7) begin
      // well-formed text with one byte overwritten by anything nonzero
      add_number(t);
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(1, 255));
    end else if (kind == 8) begin
      repeat ($urandom_range(0, 6)) t.push_back(8'($urandom_range(1, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          t.push_back(CH_PLUS);
          add_str(t, $sformatf("%0d", $urandom_range(0, 999)));
        end
        1: begin
          t.push_back(CH_MINUS);
          repeat ($urandom_range(0, 2)) t.push_back(pick_blank());
        end
        2: begin
          t.push_back(CH_MINUS);
          t.push_back(CH_MINUS);
          add_str(t, $sformatf("%0d", $urandom_range(0, 999)));
        end
        default: begin
          add_str(t, $sformatf("%0d", $urandom_range(0, 999)));
          t.push_back(pick_blank());
          add_str(t, $sformatf("%0d", $urandom_range(0, 999)));
        end
      endcase
    end
    t.push_back(CH_NUL);
  endtask

  task automatic run_directed();
    logic [CHAR_W-1:0] t[$];
    // empty text
    t = '{CH_NUL};
    send_text(t);
    // whitespace only, every blank kind
    t = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_NUL};
    send_text(t);
    // lone minus
    t = '{CH_MINUS, CH_NUL};
    send_text(t);
    // plus sign is rejected
    t = '{CH_PLUS, CH_ZERO + 8'd1, CH_NUL};
    send_text(t);
    // most negative value
    t.delete();
    add_str(t, "-2147483648");
    t.push_back(CH_NUL);
    send_text(t);
  endtask

  // let the last terminator settle and its result drain before touching config
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fallback(input logic [VALUE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.fallback = v;
  endtask

  function automatic logic [VALUE_W-1:0] fallback_for(int p);
    case (p)
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      6: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [CHAR_W-1:0] t[$];
    int                waited;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first phase runs on the reset fallback of zero
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        write_fallback(fallback_for(p));
      end
      while (bytes_sent < (p + 1) * BYTES_PER_PHASE) begin
        make_random_text(t);
        send_text(t);
      end
    end

    in_tvalid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d texts over %0d fallback settings", bytes_sent,
             texts_sent, NUM_PHASES);
    $display("checked %0d results, %0d of them fallbacks, %0d mismatches", sb.checked,
             sb.fallbacks, sb.errors);
    if (sb.errors == 0) begin
      $display("decimal_text_to_int32_core regression: pass");
    end else begin
      $display("decimal_text_to_int32_core regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dtti_pkg.sv
rtl/dtti_in_stage.sv
rtl/dtti_parse.sv
rtl/dtti_out_stage.sv
rtl/decimal_text_to_int32_core.sv
rtl/dtti_checker.sv
tb/tb_decimal_text_to_int32_core.sv
